FILE: rtl/sgenc_pkg.sv
// shared types, constants and tables for the srgb oetf encoder
package sgenc_pkg;

   localparam int DATA_WIDTH = 20;
   localparam int FRAC_BITS  = 16;
   localparam int CLIP_WIDTH = DATA_WIDTH - 1;

   // configuration port
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CLIP_CEIL = 8'd0,
      CSR_ENABLE    = 8'd1
   } csr_index_type;
   localparam logic [CLIP_WIDTH-1:0] CLIP_RESET = CLIP_WIDTH'(1 << FRAC_BITS);

   // mantissa and roots are kept in q30
   localparam int Q_FRAC     = 30;
   localparam int MQ_W       = Q_FRAC + 1;
   localparam int ROOT_W     = 31;
   localparam int ROOT_STEPS = 31;
   localparam int SQ_IN_W    = MQ_W + Q_FRAC;
   localparam int SQ_TRIAL_W = 64;
   localparam int CB_IN_W    = MQ_W + 2 * Q_FRAC;
   localparam int CB_Y2_W    = 2 * ROOT_W;
   localparam int CB_TRIAL_W = 96;

   // exponent handling
   localparam int E_W = 5;
   localparam int N_W = 5;
   localparam int R_W = 4;

   // linear segment
   localparam int LIN_THRESH = int'((64'd31308 << FRAC_BITS) / 64'd10000000);
   localparam int LIN_X_W    = 8;
   localparam int LIN_MUL    = 1292;
   localparam int LIN_ROUND  = 50;
   localparam int LIN_T_W    = 19;
   localparam int LIN_RECIP  = 671089;
   localparam int LIN_SHIFT  = 26;
   localparam int LIN_P_W    = 39;
   localparam int LIN_Y_W    = LIN_P_W - LIN_SHIFT;

   // power segment
   localparam int P_W       = 32;
   localparam int P12_W     = 31;
   localparam int G_W       = 33;
   localparam int A_W       = 44;
   localparam int POW_GAIN  = 1055;
   localparam int POW_OFS   = 55;
   localparam int POW_ROUND = 500;
   localparam int V_W       = 30;
   localparam int DIV_RECIP = 274877907;
   localparam int DIV_SHIFT = 38;
   localparam int QP_W      = 59;
   localparam int PW_Y_W    = QP_W - DIV_SHIFT;

   localparam logic [PW_Y_W-1:0] CH_MAX = PW_Y_W'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);

   // pipeline depth of one lane after the input stage, and of the valid chain
   localparam int SIDE_DEPTH  = 2 * ROOT_STEPS + 6;
   localparam int TAP_P       = 2 * ROOT_STEPS + 1;
   localparam int TAP_D       = 2 * ROOT_STEPS + 3;
   localparam int VALID_DEPTH = SIDE_DEPTH + 2;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] red_in;
      logic signed [DATA_WIDTH-1:0] green_in;
      logic signed [DATA_WIDTH-1:0] blue_in;
   } pix_in_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] red_out;
      logic signed [DATA_WIDTH-1:0] green_out;
      logic signed [DATA_WIDTH-1:0] blue_out;
   } pix_out_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] raw;
      logic                  bypass;
      logic                  lin;
      logic [LIN_T_W-1:0]    lin_t;
      logic [N_W-1:0]        n;
      logic [R_W-1:0]        r;
   } side_type;

   // 2^(r/12) in q30
   function automatic logic [P12_W-1:0] p12(input logic [R_W-1:0] r);
      logic [P12_W-1:0] v;
      unique case (r)
         4'd0:    v = 31'd1073741824;
         4'd1:    v = 31'd1137589835;
         4'd2:    v = 31'd1205234447;
         4'd3:    v = 31'd1276901417;
         4'd4:    v = 31'd1352829926;
         4'd5:    v = 31'd1433273380;
         4'd6:    v = 31'd1518500250;
         4'd7:    v = 31'd1608794973;
         4'd8:    v = 31'd1704458901;
         4'd9:    v = 31'd1805811301;
         4'd10:   v = 31'd1913190429;
         4'd11:   v = 31'd2026954652;
         default: v = 31'd1073741824;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/sgenc_ifs.sv
// valid/ready channel interfaces for pixels and configuration writes
interface sgenc_req_if;
   import sgenc_pkg::*;
   logic       valid;
   logic       ready;
   pix_in_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

interface sgenc_rsp_if;
   import sgenc_pkg::*;
   logic        valid;
   logic        ready;
   pix_out_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

interface sgenc_csr_if;
   import sgenc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;
   modport source(output valid, output index, output wdata, input ready);
   modport sink(input valid, input index, input wdata, output ready);
endinterface

FILE: rtl/sgenc_isqrt.sv
// pipelined floor square root, one result bit per stage
module sgenc_isqrt (
   input  logic                             clock,
   input  logic                             adv,
   input  logic [sgenc_pkg::SQ_IN_W-1:0]    radicand,
   output logic [sgenc_pkg::ROOT_W-1:0]     root
);
   import sgenc_pkg::*;

   logic [SQ_IN_W-1:0] rem_ff [ROOT_STEPS];
   logic [ROOT_W-1:0]  y_ff   [ROOT_STEPS];

   for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
      localparam int B = ROOT_STEPS - 1 - k;
      logic [SQ_IN_W-1:0]    rem_cur;
      logic [ROOT_W-1:0]     y_cur;
      logic [SQ_TRIAL_W-1:0] trial;

      if (k == 0) begin : g_first
         assign rem_cur = radicand;
         assign y_cur   = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[k-1];
         assign y_cur   = y_ff[k-1];
      end

      // (y + 2^b)^2 - y^2
      assign trial = (SQ_TRIAL_W'(y_cur) << (B + 1)) + (SQ_TRIAL_W'(1) << (2 * B));

      always_ff @(posedge clock) begin
         if (adv) begin
            if (trial <= SQ_TRIAL_W'(rem_cur)) begin
               rem_ff[k] <= rem_cur - trial[SQ_IN_W-1:0];
               y_ff[k]   <= y_cur | (ROOT_W'(1) << B);
            end else begin
               rem_ff[k] <= rem_cur;
               y_ff[k]   <= y_cur;
            end
         end
      end
   end

   assign root = y_ff[ROOT_STEPS-1];

endmodule

FILE: rtl/sgenc_icbrt.sv
// pipelined floor cube root, one result bit per stage
module sgenc_icbrt (
   input  logic                             clock,
   input  logic                             adv,
   input  logic [sgenc_pkg::CB_IN_W-1:0]    radicand,
   output logic [sgenc_pkg::ROOT_W-1:0]     root
);
   import sgenc_pkg::*;

   logic [CB_IN_W-1:0] rem_ff [ROOT_STEPS];
   logic [ROOT_W-1:0]  y_ff   [ROOT_STEPS];
   logic [CB_Y2_W-1:0] y2_ff  [ROOT_STEPS];

   for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
      localparam int B = ROOT_STEPS - 1 - k;
      logic [CB_IN_W-1:0]    rem_cur;
      logic [ROOT_W-1:0]     y_cur;
      logic [CB_Y2_W-1:0]    y2_cur;
      logic [CB_TRIAL_W-1:0] trial;
      logic [CB_Y2_W-1:0]    y2_up;

      if (k == 0) begin : g_first
         assign rem_cur = radicand;
         assign y_cur   = '0;
         assign y2_cur  = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[k-1];
         assign y_cur   = y_ff[k-1];
         assign y2_cur  = y2_ff[k-1];
      end

      // (y + 2^b)^3 - y^3 = 3y^2 2^b + 3y 2^2b + 2^3b
      assign trial = ((CB_TRIAL_W'(y2_cur) * CB_TRIAL_W'(3)) << B)
                   + ((CB_TRIAL_W'(y_cur) * CB_TRIAL_W'(3)) << (2 * B))
                   + (CB_TRIAL_W'(1) << (3 * B));
      assign y2_up = y2_cur + (CB_Y2_W'(y_cur) << (B + 1)) + (CB_Y2_W'(1) << (2 * B));

      always_ff @(posedge clock) begin
         if (adv) begin
            if (trial <= CB_TRIAL_W'(rem_cur)) begin
               rem_ff[k] <= rem_cur - trial[CB_IN_W-1:0];
               y_ff[k]   <= y_cur | (ROOT_W'(1) << B);
               y2_ff[k]  <= y2_up;
            end else begin
               rem_ff[k] <= rem_cur;
               y_ff[k]   <= y_cur;
               y2_ff[k]  <= y2_cur;
            end
         end
      end
   end

   assign root = y_ff[ROOT_STEPS-1];

endmodule

FILE: rtl/sgenc_lane.sv
// one channel of the encoder: clip, linear segment, power segment and bypass
module sgenc_lane (
   input  logic                                    clock,
   input  logic                                    adv,
   input  logic                                    enable,
   input  logic [sgenc_pkg::CLIP_WIDTH-1:0]        clip_ceil,
   input  logic signed [sgenc_pkg::DATA_WIDTH-1:0] chan_in,
   output logic signed [sgenc_pkg::DATA_WIDTH-1:0] chan_out
);
   import sgenc_pkg::*;

   // n = 30 - frac - floor(5(e - frac)/12), by msb position
   function automatic logic [N_W-1:0] exp_n(input logic [E_W-1:0] e);
      logic [N_W-1:0] v;
      unique case (e)
         5'd0, 5'd1:                 v = 5'd21;
         5'd2, 5'd3:                 v = 5'd20;
         5'd4, 5'd5, 5'd6:           v = 5'd19;
         5'd7, 5'd8:                 v = 5'd18;
         5'd9, 5'd10, 5'd11:         v = 5'd17;
         5'd12, 5'd13:               v = 5'd16;
         5'd14, 5'd15:               v = 5'd15;
         default:                    v = 5'd14;
      endcase
      return v;
   endfunction

   // remainder of 5(e - frac) modulo 12
   function automatic logic [R_W-1:0] exp_r(input logic [E_W-1:0] e);
      logic [R_W-1:0] v;
      unique case (e)
         5'd0:    v = 4'd4;
         5'd1:    v = 4'd9;
         5'd2:    v = 4'd2;
         5'd3:    v = 4'd7;
         5'd4:    v = 4'd0;
         5'd5:    v = 4'd5;
         5'd6:    v = 4'd10;
         5'd7:    v = 4'd3;
         5'd8:    v = 4'd8;
         5'd9:    v = 4'd1;
         5'd10:   v = 4'd6;
         5'd11:   v = 4'd11;
         5'd12:   v = 4'd4;
         5'd13:   v = 4'd9;
         5'd14:   v = 4'd2;
         5'd15:   v = 4'd7;
         5'd16:   v = 4'd0;
         5'd17:   v = 4'd5;
         5'd18:   v = 4'd10;
         default: v = 4'd0;
      endcase
      return v;
   endfunction

   // clip stage
   logic signed [DATA_WIDTH-1:0] clip_s;
   logic signed [DATA_WIDTH-1:0] lim;
   logic [CLIP_WIDTH-1:0]        in_x_in;
   logic [DATA_WIDTH-1:0]        in_raw_ff;
   logic [CLIP_WIDTH-1:0]        in_x_ff;
   logic                         in_byp_ff;

   assign clip_s  = $signed({1'b0, clip_ceil});
   assign lim     = (chan_in < clip_s) ? chan_in : clip_s;
   assign in_x_in = lim[DATA_WIDTH-1] ? '0 : lim[CLIP_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         in_raw_ff <= chan_in;
         in_x_ff   <= in_x_in;
         in_byp_ff <= !enable;
      end
   end

   // normalize stage
   logic [E_W-1:0]  e;
   logic [MQ_W-1:0] mq_in;
   logic [MQ_W-1:0] mq_ff;
   side_type        side_in;
   side_type        side_ff [SIDE_DEPTH];

   always_comb begin
      e = '0;
      for (int i = 0; i < CLIP_WIDTH; i++) begin
         if (in_x_ff[i]) begin
            e = E_W'(i);
         end
      end
   end

   assign mq_in          = MQ_W'(in_x_ff) << (E_W'(Q_FRAC) - e);
   assign side_in.raw    = in_raw_ff;
   assign side_in.bypass = in_byp_ff;
   assign side_in.lin    = in_x_ff <= CLIP_WIDTH'(LIN_THRESH);
   assign side_in.lin_t  = LIN_T_W'(in_x_ff[LIN_X_W-1:0]) * LIN_T_W'(LIN_MUL)
                         + LIN_T_W'(LIN_ROUND);
   assign side_in.n      = exp_n(e);
   assign side_in.r      = exp_r(e);

   always_ff @(posedge clock) begin
      if (adv) begin
         mq_ff      <= mq_in;
         side_ff[0] <= side_in;
         for (int k = 1; k < SIDE_DEPTH; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // roots: m^(1/4) and m^(1/6)
   logic [ROOT_W-1:0] s1, s2, cb, s3;

   sgenc_isqrt u_sqrt_m (
      .clock    (clock),
      .adv      (adv),
      .radicand ({mq_ff, {Q_FRAC{1'b0}}}),
      .root     (s1)
   );

   sgenc_isqrt u_sqrt_s1 (
      .clock    (clock),
      .adv      (adv),
      .radicand ({s1, {Q_FRAC{1'b0}}}),
      .root     (s2)
   );

   sgenc_icbrt u_cbrt_m (
      .clock    (clock),
      .adv      (adv),
      .radicand ({mq_ff, {(2 * Q_FRAC){1'b0}}}),
      .root     (cb)
   );

   sgenc_isqrt u_sqrt_cb (
      .clock    (clock),
      .adv      (adv),
      .radicand ({cb, {Q_FRAC{1'b0}}}),
      .root     (s3)
   );

   // tail: product, octave scale, gain and offset, divide by 1000
   logic [2*ROOT_W-1:0]       prod_p;
   logic [P_W-1:0]            p_ff;
   logic [P_W+P12_W-1:0]      prod_g;
   logic [G_W-1:0]            g_ff;
   logic [A_W-1:0]            gain_ff;
   logic [A_W-1:0]            sub;
   logic [A_W-1:0]            diff;
   logic [A_W-1:0]            diff_sh;
   logic [V_W-1:0]            v_in;
   logic [V_W-1:0]            v_ff;
   logic [QP_W-1:0]           qp_ff;

   assign prod_p  = s2 * s3;
   assign prod_g  = p_ff * p12(side_ff[TAP_P].r);
   assign sub     = A_W'(POW_OFS) << (FRAC_BITS + int'(side_ff[TAP_D].n));
   assign diff    = (gain_ff > sub) ? (gain_ff - sub) : '0;
   assign diff_sh = diff >> side_ff[TAP_D].n;
   assign v_in    = diff_sh[V_W-1:0] + V_W'(POW_ROUND);

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff    <= prod_p[Q_FRAC+P_W-1:Q_FRAC];
         g_ff    <= prod_g[Q_FRAC+G_W-1:Q_FRAC];
         gain_ff <= A_W'(g_ff) * A_W'(POW_GAIN);
         v_ff    <= v_in;
         qp_ff   <= QP_W'(v_ff) * QP_W'(DIV_RECIP);
      end
   end

   // select and saturate
   side_type            side_q;
   logic [LIN_P_W-1:0]  lin_prod;
   logic [PW_Y_W-1:0]   curve;
   logic [PW_Y_W-1:0]   curve_sat;

   assign side_q    = side_ff[SIDE_DEPTH-1];
   assign lin_prod  = LIN_P_W'(side_q.lin_t) * LIN_P_W'(LIN_RECIP);
   assign curve     = side_q.lin ? PW_Y_W'(lin_prod[LIN_P_W-1:LIN_SHIFT])
                                 : qp_ff[QP_W-1:DIV_SHIFT];
   assign curve_sat = (curve > CH_MAX) ? CH_MAX : curve;
   assign chan_out  = side_q.bypass ? $signed(side_q.raw)
                                    : $signed(DATA_WIDTH'(curve_sat));

endmodule

FILE: rtl/srgb_oetf_encoder_top.sv
// top level of the srgb oetf encoder: three channel lanes and output merge
//
//  channel  dir  handshake      payload
//  req_bus  in   valid/ready    red_in, green_in, blue_in (signed q4.16)
//  rsp_bus  out  valid/ready    red_out, green_out, blue_out (signed q4.16)
//  csr_bus  in   valid/ready    index (0 clip_ceil, 1 enable), wdata
//
// one item per clock sustained while rsp_bus.ready stays high; the depth is set by the two chained
// 31-stage root pipelines (sqrt of sqrt, sqrt of cbrt) in each lane
// synchronous reset clears the valid chain and loads clip_ceil = 1.0, enable = 1
// the whole pipeline holds while a result sits in the output register
// and rsp_bus.ready is low; csr writes are always taken
module srgb_oetf_encoder_top (
   input logic          clock,
   input logic          reset,
   sgenc_req_if.sink    req_bus,
   sgenc_rsp_if.source  rsp_bus,
   sgenc_csr_if.sink    csr_bus
);
   import sgenc_pkg::*;

   // configuration registers
   logic [CLIP_WIDTH-1:0] clip_ceil_ff;
   logic                  enable_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_ceil_ff <= CLIP_RESET;
         enable_ff    <= 1'b1;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_CLIP_CEIL: clip_ceil_ff <= csr_bus.wdata[CLIP_WIDTH-1:0];
            CSR_ENABLE:    enable_ff    <= csr_bus.wdata[0];
            default:       ;  // unknown register, ignored
         endcase
      end
   end

   // pipeline advance: everything moves when the output slot frees up
   logic                   adv;
   logic [VALID_DEPTH-1:0] valid_ff;

   assign adv           = !valid_ff[VALID_DEPTH-1] || rsp_bus.ready;
   assign req_bus.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[VALID_DEPTH-2:0], req_bus.valid};
      end
   end

   // three identical lanes, one per color channel
   logic signed [DATA_WIDTH-1:0] red_y, green_y, blue_y;

   sgenc_lane u_lane_red (
      .clock     (clock),
      .adv       (adv),
      .enable    (enable_ff),
      .clip_ceil (clip_ceil_ff),
      .chan_in   (req_bus.data.red_in),
      .chan_out  (red_y)
   );

   sgenc_lane u_lane_green (
      .clock     (clock),
      .adv       (adv),
      .enable    (enable_ff),
      .clip_ceil (clip_ceil_ff),
      .chan_in   (req_bus.data.green_in),
      .chan_out  (green_y)
   );

   sgenc_lane u_lane_blue (
      .clock     (clock),
      .adv       (adv),
      .enable    (enable_ff),
      .clip_ceil (clip_ceil_ff),
      .chan_in   (req_bus.data.blue_in),
      .chan_out  (blue_y)
   );

   // merge the lane results into the output register
   pix_out_type rsp_data_in;
   pix_out_type rsp_data_ff;

   assign rsp_data_in.red_out   = red_y;
   assign rsp_data_in.green_out = green_y;
   assign rsp_data_in.blue_out  = blue_y;

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_bus.valid = valid_ff[VALID_DEPTH-1];
   assign rsp_bus.data  = rsp_data_ff;

endmodule

FILE: bench/sgenc_checker.sv
// checker for the srgb oetf encoder: watches the channels, predicts pixels and compares
module sgenc_checker
   import sgenc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  pix_in_type  req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  pix_out_type rsp_data,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int          fail_count,
   output int          pending_count
);

   localparam longint unsigned THRESH = (64'd31308 << FRAC_BITS) / 64'd10000000;
   localparam longint unsigned TOP    = (64'd1 << (DATA_WIDTH - 1)) - 1;

   logic [CLIP_WIDTH-1:0] clip_level;
   logic                  curve_on;
   pix_out_type           pixels_due[$];

   // 2^(r/12) in q30
   function automatic longint unsigned semitone(int r);
      longint unsigned t[12] = '{1073741824, 1137589835, 1205234447, 1276901417,
         1352829926, 1433273380, 1518500250, 1608794973, 1704458901,
         1805811301, 1913190429, 2026954652};
      return t[r];
   endfunction

   function automatic longint unsigned isqrt(longint unsigned v);
      longint unsigned y, c;
      y = 0;
      for (int b = 31; b >= 0; b--) begin
         c = y | (64'd1 << b);
         if (c * c <= v) y = c;
      end
      return y;
   endfunction

   function automatic longint unsigned icbrt_q30(longint unsigned mq);
      logic [127:0] target, cube;
      longint unsigned y, c;
      target = {64'd0, mq} << 60;
      y = 0;
      for (int b = 31; b >= 0; b--) begin
         c = y | (64'd1 << b);
         cube = 128'(c) * 128'(c) * 128'(c);
         if (cube <= target) y = c;
      end
      return y;
   endfunction

   function automatic longint unsigned gamma_root(longint unsigned x);
      int e, ex, t, q, r, n;
      longint unsigned mq, s2, s3, p, g, a, sub, d;
      e = 0;
      while (e < 63 && (x >> (e + 1)) != 0) e++;
      if (e > 30) e = 30;
      mq = x << (30 - e);
      ex = e - FRAC_BITS;
      t = 5 * ex;
      if (t >= 0) q = t / 12;
      else q = -((-t + 11) / 12);
      r = t - 12 * q;
      if (r < 0 || r > 11) r = 0;
      s2 = isqrt(isqrt(mq << 30) << 30);
      s3 = isqrt(icbrt_q30(mq) << 30);
      p = (s2 * s3) >> 30;
      g = (p * semitone(r)) >> 30;
      n = 30 - FRAC_BITS - q;
      if (n < 1) n = 1;
      if (n > 40) n = 40;
      a = g * 1055;
      sub = (64'd55 << FRAC_BITS) << n;
      d = (a > sub) ? a - sub : 0;
      return (d + (64'd500 << n)) / (64'd1000 << n);
   endfunction

   function automatic logic [DATA_WIDTH-1:0] encode_chan(logic signed [DATA_WIDTH-1:0] raw);
      longint v, x;
      longint unsigned y;
      if (!curve_on) return raw;
      v = raw;
      x = (v < longint'(clip_level)) ? v : longint'(clip_level);
      if (x < 0) x = 0;
      if (x <= THRESH) y = (x * 1292 + 50) / 100;
      else y = gamma_root(x);
      if (y > TOP) y = TOP;
      return y[DATA_WIDTH-1:0];
   endfunction

   assign pending_count = pixels_due.size();

   always @(posedge clock) begin
      pix_out_type e;
      if (reset) begin
         clip_level <= CLIP_RESET;
         curve_on   <= 1'b1;
         pixels_due.delete();
         fail_count <= 0;
      end else begin
         // prediction uses the settings in force before any write this edge
         if (req_valid && req_ready) begin
            e.red_out   = encode_chan(req_data.red_in);
            e.green_out = encode_chan(req_data.green_in);
            e.blue_out  = encode_chan(req_data.blue_in);
            pixels_due.push_back(e);
         end
         if (rsp_valid && rsp_ready) begin
            if (pixels_due.size() == 0) begin
               if (fail_count < 10) $display("unexpected pixel %h", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               e = pixels_due.pop_front();
               if (e !== rsp_data) begin
                  if (fail_count < 10)
                     $display("pixel mismatch: exp %h %h %h got %h %h %h",
                        e.red_out, e.green_out, e.blue_out,
                        rsp_data.red_out, rsp_data.green_out, rsp_data.blue_out);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_CLIP_CEIL) clip_level <= csr_wdata[CLIP_WIDTH-1:0];
            else if (csr_index == CSR_ENABLE) curve_on <= csr_wdata[0];
         end
      end
   end

endmodule

FILE: bench/tb_srgb_oetf_encoder_top.sv
// testbench top for the srgb oetf encoder: stimulus, reset and verdict
module tb_srgb_oetf_encoder_top;
   import sgenc_pkg::*;

   localparam int LATENCY    = VALID_DEPTH + 10;
   localparam int CYCLE_CAP  = 400000;
   localparam int RAND_ITEMS = 1950;
   localparam csr_index_type CSR_UNUSED = csr_index_type'(8'd7);

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycles = 0;
   int   fail_count, pending_count;
   bit   calm = 1'b0;       // last part: no idling on either side
   int   hold_off = 0;      // long receiver stall, counted in its own process

   sgenc_req_if req_bus();
   sgenc_rsp_if rsp_bus();
   sgenc_csr_if csr_bus();

   srgb_oetf_encoder_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   sgenc_checker chk (
      .clock(clock), .reset(reset),
      .req_valid(req_bus.valid), .req_ready(req_bus.ready), .req_data(req_bus.data),
      .rsp_valid(rsp_bus.valid), .rsp_ready(rsp_bus.ready), .rsp_data(rsp_bus.data),
      .csr_valid(csr_bus.valid), .csr_ready(csr_bus.ready),
      .csr_index(csr_bus.index), .csr_wdata(csr_bus.wdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always #5 clock = ~clock;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.data  = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_CLIP_CEIL;
      csr_bus.wdata = '0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("tb_srgb_oetf_encoder_top: errors");
         $finish;
      end
   end

   // receiver: random stall bursts, a long hold-off on request, none at the end
   initial begin
      int burst;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (hold_off) @(posedge clock);
            hold_off = 0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 8);
            rsp_bus.ready <= 1'b0;
            repeat (burst) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // one random channel value with a spread over interesting regions
   function automatic logic [DATA_WIDTH-1:0] pick_chan();
      case ($urandom_range(0, 6))
         0: return DATA_WIDTH'($urandom_range(0, 2 * LIN_THRESH + 4));
         1: return DATA_WIDTH'($urandom_range(0, 65536));
         2: return DATA_WIDTH'($urandom_range(0, 8191));
         3: return DATA_WIDTH'(-$urandom_range(0, 2000));
         4: return DATA_WIDTH'($urandom_range(65000, 70000));
         default: return DATA_WIDTH'($urandom);
      endcase
   endfunction

   // one pixel, waiting for acceptance, with optional idle burst first
   task automatic send_pixel(input pix_in_type px, input bit idle_ok);
      if (idle_ok && !calm && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data  <= px;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic drop_valid();
      req_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait until every expected pixel has come, then let the pipe settle
   task automatic drain();
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_mono(input logic [DATA_WIDTH-1:0] v);
      pix_in_type px;
      px.red_in = v; px.green_in = ~v; px.blue_in = v ^ 20'h5a5a5;
      send_pixel(px, 1'b0);
   endtask

   initial begin
      pix_in_type px;
      logic [DATA_WIDTH-1:0] edge_vals[12];
      int phase_len;
      edge_vals = '{20'h00000, 20'h00001, DATA_WIDTH'(LIN_THRESH),
                    DATA_WIDTH'(LIN_THRESH + 1), 20'h10000,
                    20'h0ffff, 20'h7ffff, 20'h80000, 20'hfffff, 20'h00010,
                    20'h3ffff, 20'h40000};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, threshold edges, negatives, saturation
      foreach (edge_vals[i]) send_mono(edge_vals[i]);
      drop_valid();
      drain();
      write_csr(CSR_CLIP_CEIL, 32'h7ffff);     // widest clip: outputs still stay below saturation
      foreach (edge_vals[i]) send_mono(edge_vals[i]);
      drop_valid();
      drain();
      write_csr(CSR_CLIP_CEIL, 32'h0);         // zero clip: all encode to zero
      send_mono(20'h12345); send_mono(20'h7ffff);
      drop_valid();
      drain();
      write_csr(CSR_ENABLE, 32'hfffffffe);     // bypass, upper bits ignored
      send_mono(20'h80000); send_mono(20'hfffff); send_mono(20'h7ffff);
      drop_valid();
      drain();
      write_csr(CSR_UNUSED, 32'hffffffff);     // unknown index does nothing
      write_csr(CSR_ENABLE, 32'h1);
      write_csr(CSR_CLIP_CEIL, 32'hfff80000 | 32'h10000); // bits beyond width ignored

      // random phases under varied settings
      for (int ph = 0; ph < 6; ph++) begin
         phase_len = RAND_ITEMS / 6;
         if (ph == 5) calm = 1'b1;
         for (int k = 0; k < phase_len; k++) begin
            px.red_in = pick_chan(); px.green_in = pick_chan(); px.blue_in = pick_chan();
            if (ph == 1 && k == 20) hold_off = 300;   // fill pipe, stall input
            send_pixel(px, 1'b1);
         end
         drop_valid();
         drain();                               // sender pause till all results came
         case (ph)
            0: write_csr(CSR_CLIP_CEIL, $urandom_range(1, 524287));
            1: write_csr(CSR_CLIP_CEIL, 32'h7ffff);
            2: write_csr(CSR_ENABLE, 32'h0);
            3: begin
               write_csr(CSR_ENABLE, 32'h1);
               write_csr(CSR_CLIP_CEIL, $urandom_range(0, 300));
            end
            default: write_csr(CSR_CLIP_CEIL, 32'h10000);
         endcase
      end

      if (fail_count == 0)
         $display("tb_srgb_oetf_encoder_top: clean");
      else
         $display("tb_srgb_oetf_encoder_top: errors");
      $finish;
   end

endmodule
